// ===== src/assert_macros.svh =====
// Assertion macros shared by the frame parser RTL.
// Included by every module that carries concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication or plain property checked on every rising clock edge outside reset.
`define GBFP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// Condition that must never be true outside reset.
`define GBFP_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define GBFP_ASSERT(label, clk, rst, prop)
`define GBFP_NEVER(label, clk, rst, cond)
`endif
`endif

// ===== src/gbfp_pkg.sv =====
// Shared types and constants of the binary frame parser.
// Used by gbfp_parser and the gnss_binary_frame_parser top level; depends on nothing else.
`default_nettype none

package gbfp_pkg;

   // Payload buffer size per bank and the derived address widths.
   localparam int BUF_BYTES = 128;
   localparam int BUF_AW    = $clog2(BUF_BYTES);
   localparam int RAM_AW    = BUF_AW + 1;
   localparam logic [15:0] BUF_LIMIT = 16'(BUF_BYTES);

   // Configuration register indexes and reset values.
   localparam int CSR_AW = 3;
   localparam logic [CSR_AW-1:0] CSR_SYNC_FIRST  = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_SYNC_SECOND = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_FIX_CLASS   = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_FIX_ID      = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_FIX_LENGTH  = 3'd4;

   localparam logic [7:0] RST_SYNC_FIRST  = 8'd181;
   localparam logic [7:0] RST_SYNC_SECOND = 8'd98;
   localparam logic [7:0] RST_FIX_CLASS   = 8'd1;
   localparam logic [7:0] RST_FIX_ID      = 8'd7;
   localparam logic [7:0] RST_FIX_LENGTH  = 8'd92;

   // Commands carried with each input beat.
   localparam logic [1:0] CMD_RX     = 2'd0;
   localparam logic [1:0] CMD_READ   = 2'd1;
   localparam logic [1:0] CMD_RESYNC = 2'd2;

   // Result event codes.
   localparam logic [1:0] EV_NONE  = 2'd0;
   localparam logic [1:0] EV_OTHER = 2'd1;
   localparam logic [1:0] EV_FIX   = 2'd2;
   localparam logic [1:0] EV_BAD   = 2'd3;

   typedef enum logic [3:0] {
      PH_SYNC1,
      PH_SYNC2,
      PH_CLASS,
      PH_ID,
      PH_LEN1,
      PH_LEN2,
      PH_PAYLOAD,
      PH_CKA,
      PH_CKB
   } phase_type;

   typedef struct packed {
      logic [7:0] sync_first;
      logic [7:0] sync_second;
      logic [7:0] fix_class;
      logic [7:0] fix_id;
      logic [7:0] fix_length;
   } cfg_type;

   // Payload memory access issued by the parser for one beat.
   typedef struct packed {
      logic              we;
      logic [RAM_AW-1:0] waddr;
      logic [7:0]        wdata;
      logic              re;
      logic [RAM_AW-1:0] raddr;
   } mem_req_type;

   // Result of one beat, apart from the fix byte that the memory returns later.
   typedef struct packed {
      logic [1:0]  event_res;
      logic [7:0]  frame_class;
      logic [7:0]  frame_id;
      logic [15:0] frame_length;
      logic        read_hit;
      logic        fix_valid;
   } step_type;

endpackage

`default_nettype wire

// ===== src/gbfp_ram.sv =====
// Simple dual-port synchronous RAM with one write and one registered read port.
// Generic; no package dependencies.
`default_nettype none

module gbfp_ram #(
   parameter int ADDR_W = 8,
   parameter int DATA_W = 8
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [DATA_W-1:0] wdata,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Read data is held until the next read so a stalled consumer keeps it.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== src/gbfp_parser.sv =====
// Frame parser state machine, Fletcher sum and fix bank control.
// Depends on gbfp_pkg and assert_macros.svh; drives the payload memory requests.
`default_nettype none
`include "assert_macros.svh"

module gbfp_parser (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [1:0]            command,
   input  wire logic [7:0]            rx_byte,
   input  wire logic [6:0]            fix_index,
   input  wire gbfp_pkg::cfg_type     cfg,
   output gbfp_pkg::mem_req_type      mem_req,
   output gbfp_pkg::step_type         step
);

   gbfp_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  held_class_ff, held_class_in;
   logic [7:0]  held_id_ff, held_id_in;
   logic [15:0] held_length_ff, held_length_in;
   logic [15:0] payload_count_ff, payload_count_in;
   logic [7:0]  sum_low_ff, sum_low_in;
   logic [7:0]  sum_high_ff, sum_high_in;
   logic [7:0]  check_low_ff, check_low_in;
   logic        bank_sel_ff, bank_sel_in;
   logic        fix_present_ff, fix_present_in;

   logic [7:0]  low_add;
   logic [15:0] count_inc;
   logic [15:0] len_new;
   logic        fix_match;

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= gbfp_pkg::PH_SYNC1;
         held_class_ff    <= '0;
         held_id_ff       <= '0;
         held_length_ff   <= '0;
         payload_count_ff <= '0;
         sum_low_ff       <= '0;
         sum_high_ff      <= '0;
         check_low_ff     <= '0;
         bank_sel_ff      <= 1'b0;
         fix_present_ff   <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         held_class_ff    <= held_class_in;
         held_id_ff       <= held_id_in;
         held_length_ff   <= held_length_in;
         payload_count_ff <= payload_count_in;
         sum_low_ff       <= sum_low_in;
         sum_high_ff      <= sum_high_in;
         check_low_ff     <= check_low_in;
         bank_sel_ff      <= bank_sel_in;
         fix_present_ff   <= fix_present_in;
      end
   end

   // Running sum terms shared by the header and payload phases.
   assign low_add   = sum_low_ff + rx_byte;
   assign count_inc = payload_count_ff + 16'd1;
   assign len_new   = {rx_byte, held_length_ff[7:0]};
   assign fix_match = (held_class_ff == cfg.fix_class) && (held_id_ff == cfg.fix_id) &&
                      (held_length_ff == {8'd0, cfg.fix_length}) &&
                      ({8'd0, cfg.fix_length} <= gbfp_pkg::BUF_LIMIT);

   // Next state, memory requests and the result of the accepted beat.
   always_comb begin
      phase_in         = phase_ff;
      held_class_in    = held_class_ff;
      held_id_in       = held_id_ff;
      held_length_in   = held_length_ff;
      payload_count_in = payload_count_ff;
      sum_low_in       = sum_low_ff;
      sum_high_in      = sum_high_ff;
      check_low_in     = check_low_ff;
      bank_sel_in      = bank_sel_ff;
      fix_present_in   = fix_present_ff;

      mem_req.we    = 1'b0;
      mem_req.waddr = {~bank_sel_ff, payload_count_ff[gbfp_pkg::BUF_AW-1:0]};
      mem_req.wdata = rx_byte;
      mem_req.re    = 1'b0;
      mem_req.raddr = {bank_sel_ff, gbfp_pkg::BUF_AW'(fix_index)};

      step = '0;

      if (accept) begin
         case (command)
            gbfp_pkg::CMD_RX: begin
               case (phase_ff)
                  gbfp_pkg::PH_SYNC1: begin
                     if (rx_byte == cfg.sync_first) begin
                        phase_in = gbfp_pkg::PH_SYNC2;
                     end
                  end
                  gbfp_pkg::PH_SYNC2: begin
                     phase_in = (rx_byte == cfg.sync_second) ? gbfp_pkg::PH_CLASS
                                                             : gbfp_pkg::PH_SYNC1;
                  end
                  gbfp_pkg::PH_CLASS: begin
                     // The sum restarts with the class byte.
                     sum_low_in    = rx_byte;
                     sum_high_in   = rx_byte;
                     held_class_in = rx_byte;
                     phase_in      = gbfp_pkg::PH_ID;
                  end
                  gbfp_pkg::PH_ID: begin
                     sum_low_in  = low_add;
                     sum_high_in = sum_high_ff + low_add;
                     held_id_in  = rx_byte;
                     phase_in    = gbfp_pkg::PH_LEN1;
                  end
                  gbfp_pkg::PH_LEN1: begin
                     sum_low_in     = low_add;
                     sum_high_in    = sum_high_ff + low_add;
                     held_length_in = {8'd0, rx_byte};
                     phase_in       = gbfp_pkg::PH_LEN2;
                  end
                  gbfp_pkg::PH_LEN2: begin
                     sum_low_in       = low_add;
                     sum_high_in      = sum_high_ff + low_add;
                     held_length_in   = len_new;
                     payload_count_in = '0;
                     phase_in = (len_new == 16'd0) ? gbfp_pkg::PH_CKA : gbfp_pkg::PH_PAYLOAD;
                  end
                  gbfp_pkg::PH_PAYLOAD: begin
                     // Bytes beyond the buffer still enter the sum.
                     sum_low_in       = low_add;
                     sum_high_in      = sum_high_ff + low_add;
                     mem_req.we       = (payload_count_ff < gbfp_pkg::BUF_LIMIT);
                     payload_count_in = count_inc;
                     if (count_inc >= held_length_ff) begin
                        phase_in = gbfp_pkg::PH_CKA;
                     end
                  end
                  gbfp_pkg::PH_CKA: begin
                     check_low_in = rx_byte;
                     phase_in     = gbfp_pkg::PH_CKB;
                  end
                  gbfp_pkg::PH_CKB: begin
                     phase_in          = gbfp_pkg::PH_SYNC1;
                     step.frame_class  = held_class_ff;
                     step.frame_id     = held_id_ff;
                     step.frame_length = held_length_ff;
                     if ((check_low_ff != sum_low_ff) || (rx_byte != sum_high_ff)) begin
                        step.event_res = gbfp_pkg::EV_BAD;
                     end else if (fix_match) begin
                        // The freshly filled bank becomes the stored fix.
                        bank_sel_in    = ~bank_sel_ff;
                        fix_present_in = 1'b1;
                        step.event_res = gbfp_pkg::EV_FIX;
                     end else begin
                        step.event_res = gbfp_pkg::EV_OTHER;
                     end
                  end
                  default: begin
                     phase_in = gbfp_pkg::PH_SYNC1;
                  end
               endcase
            end
            gbfp_pkg::CMD_READ: begin
               mem_req.re    = 1'b1;
               step.read_hit = fix_present_ff &&
                               ({9'd0, fix_index} < gbfp_pkg::BUF_LIMIT);
            end
            gbfp_pkg::CMD_RESYNC: begin
               phase_in         = gbfp_pkg::PH_SYNC1;
               payload_count_in = '0;
            end
            default: begin
            end
         endcase
      end

      step.fix_valid = fix_present_in;
   end

   // The buffer being filled is never the one holding the stored fix.
   `GBFP_ASSERT(a_write_other_bank, clock, reset,
                mem_req.we |-> (mem_req.waddr[gbfp_pkg::RAM_AW-1] != bank_sel_ff))
   // Payload writes only come from accepted payload beats.
   `GBFP_ASSERT(a_write_in_payload, clock, reset,
                mem_req.we |-> (accept && (phase_ff == gbfp_pkg::PH_PAYLOAD)))
   // Storing a fix flips the bank and marks the fix present.
   `GBFP_ASSERT(a_fix_swap, clock, reset,
                (step.event_res == gbfp_pkg::EV_FIX) |=>
                (fix_present_ff && (bank_sel_ff != $past(bank_sel_ff))))
   // Once present, a fix stays present until reset.
   `GBFP_NEVER(a_fix_sticky, clock, reset, $fell(fix_present_ff))

endmodule

`default_nettype wire

// ===== src/gnss_binary_frame_parser.sv =====
// Binary frame parser top level: stream ports, configuration registers and output pipeline.
// Depends on gbfp_pkg, gbfp_parser, gbfp_ram and assert_macros.svh.
//
// One input beat is taken every clock cycle while the result path is not stalled, and
// each beat yields exactly one result beat: accepting it updates the parser state and
// reads the fix buffer, whose registered read data joins the stage-one result as it
// moves into the output register, which presents it. The rate is set by the parser
// update and the one write plus one read per cycle of the payload memory,
// which holds two banks of BUF_BYTES bytes. The memory needs no clearing after reset;
// a fix byte is only read once a fix frame has been stored.
`default_nettype none
`include "assert_macros.svh"

module gnss_binary_frame_parser (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // Input stream
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [15:0]                   req_tdata,  // rx_byte[7:0], fix_index[14:8]
   input  wire logic [1:0]                    req_tuser,  // command[1:0]
   // Result stream
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // event_res[1:0], frame_class[9:2], frame_id[17:10], frame_length[33:18],
   // fix_data[41:34], fix_valid[42]
   output logic [47:0]                        rsp_tdata,
   // Configuration writes
   input  wire logic                          csr_we,
   input  wire logic [gbfp_pkg::CSR_AW-1:0]   csr_addr,
   input  wire logic [7:0]                    csr_wdata
);

   gbfp_pkg::cfg_type     cfg_ff;
   gbfp_pkg::mem_req_type mem_req;
   gbfp_pkg::step_type    step;
   gbfp_pkg::step_type    s1_ff;
   logic                  s1_valid_ff;
   logic                  out_valid_ff;
   logic [42:0]           out_data_ff;
   logic [7:0]            ram_rdata;
   logic [7:0]            fix_data;
   logic                  req_accept;
   logic                  s1_move;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first  <= gbfp_pkg::RST_SYNC_FIRST;
         cfg_ff.sync_second <= gbfp_pkg::RST_SYNC_SECOND;
         cfg_ff.fix_class   <= gbfp_pkg::RST_FIX_CLASS;
         cfg_ff.fix_id      <= gbfp_pkg::RST_FIX_ID;
         cfg_ff.fix_length  <= gbfp_pkg::RST_FIX_LENGTH;
      end else if (csr_we) begin
         case (csr_addr)
            gbfp_pkg::CSR_SYNC_FIRST:  cfg_ff.sync_first  <= csr_wdata;
            gbfp_pkg::CSR_SYNC_SECOND: cfg_ff.sync_second <= csr_wdata;
            gbfp_pkg::CSR_FIX_CLASS:   cfg_ff.fix_class   <= csr_wdata;
            gbfp_pkg::CSR_FIX_ID:      cfg_ff.fix_id      <= csr_wdata;
            gbfp_pkg::CSR_FIX_LENGTH:  cfg_ff.fix_length  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Stage one moves on when the output register is empty or being drained.
   assign s1_move    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign req_accept = req_tvalid && req_tready;

   gbfp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .command   (req_tuser),
      .rx_byte   (req_tdata[7:0]),
      .fix_index (req_tdata[14:8]),
      .cfg       (cfg_ff),
      .mem_req   (mem_req),
      .step      (step)
   );

   gbfp_ram #(
      .ADDR_W (gbfp_pkg::RAM_AW),
      .DATA_W (8)
   ) u_ram (
      .clock (clock),
      .we    (mem_req.we),
      .waddr (mem_req.waddr),
      .wdata (mem_req.wdata),
      .re    (mem_req.re),
      .raddr (mem_req.raddr),
      .rdata (ram_rdata)
   );

   // Stage one: parser result waiting for the memory read data.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff <= step;
      end
   end

   assign fix_data = s1_ff.read_hit ? ram_rdata : 8'd0;

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_move) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_data_ff <= {s1_ff.fix_valid, fix_data, s1_ff.frame_length,
                         s1_ff.frame_id, s1_ff.frame_class, s1_ff.event_res};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_data_ff};

   // A new beat never lands on a stage-one item that cannot move.
   `GBFP_ASSERT(a_no_overrun, clock, reset,
                (req_accept && out_valid_ff && !rsp_tready) |-> !s1_valid_ff)
   // Frame fields are zero whenever no frame completed.
   `GBFP_ASSERT(a_idle_fields_zero, clock, reset,
                (rsp_tvalid && (rsp_tdata[1:0] == gbfp_pkg::EV_NONE)) |->
                (rsp_tdata[33:2] == 32'd0))
   // No fix byte is reported before a fix is stored.
   `GBFP_ASSERT(a_no_data_without_fix, clock, reset,
                (rsp_tvalid && !rsp_tdata[42]) |-> (rsp_tdata[41:34] == 8'd0))

endmodule

`default_nettype wire
